FILE: rtl/core/integer_to_ascii_radix_assert.svh
// ----------------------------------------------------------------------------
// integer_to_ascii_radix assertion macros
// Concurrent assertion shorthands on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define I2A_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("integer_to_ascii_radix: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define I2A_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("integer_to_ascii_radix: assertion failed");

`endif

FILE: rtl/core/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared constants, types and character helpers of the integer formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

	localparam int VALUE_W        = 64;
	localparam int BCD_DIGITS     = 20;
	localparam int SR_W           = 4 * BCD_DIGITS;
	localparam int CNT_W          = 7;
	localparam int CHARS_PER_BEAT = 8;
	localparam int FILL_W         = 3;

	localparam logic [CNT_W-1:0] NDIG_HEX = 7'd16;
	localparam logic [CNT_W-1:0] NDIG_DEC = 7'd20;
	localparam logic [CNT_W-1:0] NDIG_OCT = 7'd22;
	localparam logic [CNT_W-1:0] NDIG_BIN = 7'd64;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_O     = 8'h6f;
	localparam logic [7:0] CH_B     = 8'h62;

	typedef enum logic [1:0] {
		RADIX_HEX = 2'd0,
		RADIX_DEC = 2'd1,
		RADIX_OCT = 2'd2,
		RADIX_BIN = 2'd3
	} radix_t;

	// Everything the digit sequencer needs to print one value.
	typedef struct packed {
		logic [SR_W-1:0]  digits;
		logic [CNT_W-1:0] ndig;
		radix_t           radix;
		logic             prefix;
		logic             sign;
	} i2a_load_t;

	// One character on its way to the beat packer.
	typedef struct packed {
		logic       valid;
		logic [7:0] code;
		logic       last;
	} i2a_char_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d > 4'd9) begin
			c = CH_A + {4'd0, d} - 8'd10;
		end else begin
			c = CH_ZERO + {4'd0, d};
		end
		return c;
	endfunction

	function automatic logic [7:0] radix_letter(input radix_t r);
		logic [7:0] c;
		case (r)
			RADIX_HEX: c = CH_X;
			RADIX_DEC: c = CH_D;
			RADIX_OCT: c = CH_O;
			RADIX_BIN: c = CH_B;
			default:   c = CH_X;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/core/i2a_in_if.sv
// ----------------------------------------------------------------------------
// i2a_in_if
// Input channel: the value to print and its formatting flags.
// ----------------------------------------------------------------------------
interface i2a_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  radix_code;
	logic        with_prefix;
	logic        negative;

	modport source (output valid, output value, output radix_code,
		output with_prefix, output negative, input ready);
	modport sink (input valid, input value, input radix_code,
		input with_prefix, input negative, output ready);
endinterface

FILE: rtl/core/i2a_out_if.sv
// ----------------------------------------------------------------------------
// i2a_out_if
// Output channel: one beat of up to eight ASCII characters.
// ----------------------------------------------------------------------------
interface i2a_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] chars;
	logic [3:0]  char_count;
	logic        last;

	modport source (output valid, output chars, output char_count,
		output last, input ready);
	modport sink (input valid, input chars, input char_count,
		input last, output ready);
endinterface

FILE: rtl/core/i2a_dabble.sv
// ----------------------------------------------------------------------------
// i2a_dabble
// Bit-serial binary to BCD converter, one input bit per cycle (shift-add-3).
// ----------------------------------------------------------------------------
module i2a_dabble (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [i2a_pkg::VALUE_W-1:0] value,
	output logic [i2a_pkg::SR_W-1:0]    bcd,
	output logic                        done
);

	logic [i2a_pkg::VALUE_W-1:0] bin_q;
	logic [i2a_pkg::SR_W-1:0]    bcd_q;
	logic [i2a_pkg::SR_W-1:0]    adj;
	logic [i2a_pkg::CNT_W-1:0]   cnt_q;
	logic                        done_q;

	// Every BCD digit of five or more gets three added before the shift.
	always_comb begin
		adj = bcd_q;
		for (int i = 0; i < i2a_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == i2a_pkg::CNT_W'(1)) && !start;
			if (start) begin
				cnt_q <= i2a_pkg::CNT_W'(i2a_pkg::VALUE_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - i2a_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bcd_q <= {adj[i2a_pkg::SR_W-2:0], bin_q[i2a_pkg::VALUE_W-1]};
			bin_q <= {bin_q[i2a_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	assign bcd  = bcd_q;
	assign done = done_q;

endmodule

FILE: rtl/core/i2a_digits.sv
// ----------------------------------------------------------------------------
// i2a_digits
// Character sequencer: prefix or sign, then digits most significant first.
// ----------------------------------------------------------------------------
module i2a_digits (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  i2a_pkg::i2a_load_t   cfg,
	output logic                 busy,
	output i2a_pkg::i2a_char_t   chr,
	input  logic                 chr_ready
);

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_LEAD0 = 4'b0010,
		PH_LEAD1 = 4'b0100,
		PH_DIG   = 4'b1000
	} phase_t;

	phase_t                    phase_q;
	logic [i2a_pkg::SR_W-1:0]  sr_q;
	logic [i2a_pkg::CNT_W-1:0] left_q;
	i2a_pkg::radix_t           radix_q;
	logic                      prefix_q;
	logic                      started_q;
	logic [3:0]                digit;
	logic [i2a_pkg::SR_W-1:0]  sr_next;
	logic                      skip;
	logic                      take;

	localparam int TOP = i2a_pkg::SR_W - 1;

	// Current digit sits at the top of the shift register.
	always_comb begin
		case (radix_q)
			i2a_pkg::RADIX_OCT: begin
				digit   = {1'b0, sr_q[TOP -: 3]};
				sr_next = {sr_q[TOP-3:0], 3'b000};
			end
			i2a_pkg::RADIX_BIN: begin
				digit   = {3'b000, sr_q[TOP]};
				sr_next = {sr_q[TOP-1:0], 1'b0};
			end
			default: begin
				digit   = sr_q[TOP -: 4];
				sr_next = {sr_q[TOP-4:0], 4'b0000};
			end
		endcase
	end

	// Leading zeros are dropped, but the final digit always prints.
	assign skip = !started_q && (digit == 4'd0) && (left_q != i2a_pkg::CNT_W'(1));

	always_comb begin
		chr = '0;
		case (phase_q)
			PH_LEAD0: begin
				chr.valid = 1'b1;
				chr.code  = prefix_q ? i2a_pkg::CH_ZERO : i2a_pkg::CH_MINUS;
			end
			PH_LEAD1: begin
				chr.valid = 1'b1;
				chr.code  = i2a_pkg::radix_letter(radix_q);
			end
			PH_DIG: begin
				chr.valid = !skip;
				chr.code  = i2a_pkg::digit_char(digit);
				chr.last  = (left_q == i2a_pkg::CNT_W'(1));
			end
			default: begin
				chr = '0;
			end
		endcase
	end

	assign take = chr.valid && chr_ready;
	assign busy = (phase_q != PH_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			started_q <= 1'b0;
			left_q    <= '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (load) begin
						phase_q   <= (cfg.prefix || cfg.sign) ? PH_LEAD0 : PH_DIG;
						started_q <= 1'b0;
						left_q    <= cfg.ndig;
					end
				end
				PH_LEAD0: begin
					if (take) begin
						phase_q <= prefix_q ? PH_LEAD1 : PH_DIG;
					end
				end
				PH_LEAD1: begin
					if (take) begin
						phase_q <= PH_DIG;
					end
				end
				PH_DIG: begin
					if (skip || take) begin
						left_q <= left_q - i2a_pkg::CNT_W'(1);
						if (take) begin
							started_q <= 1'b1;
						end
						if (take && chr.last) begin
							phase_q <= PH_IDLE;
						end
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && load) begin
			sr_q     <= cfg.digits;
			radix_q  <= cfg.radix;
			prefix_q <= cfg.prefix;
		end else if (phase_q == PH_DIG && (skip || take)) begin
			sr_q <= sr_next;
		end
	end

endmodule

FILE: rtl/core/i2a_pack.sv
// ----------------------------------------------------------------------------
// i2a_pack
// Gathers characters into beats and holds each beat in the output register.
// ----------------------------------------------------------------------------
module i2a_pack (
	input  logic               clk,
	input  logic               arst_n,
	input  i2a_pkg::i2a_char_t chr,
	output logic               chr_ready,
	i2a_out_if.source          text
);

	logic [63:0]                buf_q;
	logic [i2a_pkg::FILL_W-1:0] fill_q;
	logic [63:0]                buf_new;
	logic                       take;
	logic                       beat_end;
	logic                       out_valid_q;
	logic [63:0]                out_chars_q;
	logic [3:0]                 out_count_q;
	logic                       out_last_q;

	// Bytes above the write position read as zero, so a short beat is clean.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			if (i2a_pkg::FILL_W'(i) == fill_q) begin
				buf_new[8*i +: 8] = chr.code;
			end else if (i2a_pkg::FILL_W'(i) < fill_q) begin
				buf_new[8*i +: 8] = buf_q[8*i +: 8];
			end else begin
				buf_new[8*i +: 8] = 8'h00;
			end
		end
	end

	assign chr_ready = !out_valid_q || text.ready;
	assign take      = chr.valid && chr_ready;
	assign beat_end  = chr.last ||
		(fill_q == i2a_pkg::FILL_W'(i2a_pkg::CHARS_PER_BEAT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (text.ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (beat_end) begin
					fill_q      <= '0;
					out_valid_q <= 1'b1;
				end else begin
					fill_q <= fill_q + i2a_pkg::FILL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q <= buf_new;
			if (beat_end) begin
				out_chars_q <= buf_new;
				out_count_q <= {1'b0, fill_q} + 4'd1;
				out_last_q  <= chr.last;
			end
		end
	end

	assign text.valid      = out_valid_q;
	assign text.chars      = out_chars_q;
	assign text.char_count = out_count_q;
	assign text.last       = out_last_q;

endmodule

FILE: rtl/core/integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Formats a 64-bit unsigned value as hex, decimal, octal or binary ASCII text.
// ----------------------------------------------------------------------------
//
//  Channel  Side    Carries
//  -------  ------  ----------------------------------------------------------
//  item     sink    value, radix_code, with_prefix, negative
//  text     source  chars (first character in low byte), char_count, last
//
//  After an item is accepted, a decimal value passes through the bit-serial BCD
//  converter, which then hands its result over. The sequencer then steps through
//  the prefix or sign characters and every digit position (16 hex, 20 decimal,
//  22 octal, 64 binary), one per cycle unless the output stalls it, and then
//  returns to idle.
//  Reset clears the control state only; no clearing pass is needed.
//  A text beat waiting in the output register stalls the character flow.
//
module integer_to_ascii_radix (
	input  logic     clk,
	input  logic     arst_n,
	i2a_in_if.sink   item,
	i2a_out_if.source text
);

	`include "integer_to_ascii_radix_assert.svh"

	// Top-level control: accept an item, convert it if decimal, then let the
	// sequencer print it before the next transaction is taken.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} ctl_state_t;

	ctl_state_t          state_q;
	logic                accept;
	i2a_pkg::radix_t     radix_in;
	logic                sign_in;
	i2a_pkg::radix_t     radix_q;
	logic                prefix_q;
	logic                sign_q;
	logic [i2a_pkg::SR_W-1:0]  bcd;
	logic                conv_done;
	logic                load;
	i2a_pkg::i2a_load_t  load_cfg;
	logic                dig_busy;
	i2a_pkg::i2a_char_t  chr;
	logic                chr_ready;

	localparam int PAD = i2a_pkg::SR_W - i2a_pkg::VALUE_W;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign radix_in   = i2a_pkg::radix_t'(item.radix_code);

	// The minus sign only appears for a decimal, unprefixed, nonzero value.
	assign sign_in = item.negative && !item.with_prefix &&
		(radix_in == i2a_pkg::RADIX_DEC) && (item.value != '0);

	// Power-of-two radices go straight to the sequencer, left aligned so that
	// the top digit sits at the top of its shift register; octal gets two
	// leading zero bits to make 22 whole digits.
	always_comb begin
		load_cfg = '0;
		load     = 1'b0;
		if (state_q == ST_CONV) begin
			load            = conv_done;
			load_cfg.digits = bcd;
			load_cfg.ndig   = i2a_pkg::NDIG_DEC;
			load_cfg.radix  = radix_q;
			load_cfg.prefix = prefix_q;
			load_cfg.sign   = sign_q;
		end else begin
			load            = accept && (radix_in != i2a_pkg::RADIX_DEC);
			load_cfg.radix  = radix_in;
			load_cfg.prefix = item.with_prefix;
			load_cfg.sign   = 1'b0;
			case (radix_in)
				i2a_pkg::RADIX_OCT: begin
					load_cfg.digits = {2'b00, item.value, {(PAD-2){1'b0}}};
					load_cfg.ndig   = i2a_pkg::NDIG_OCT;
				end
				i2a_pkg::RADIX_BIN: begin
					load_cfg.digits = {item.value, {PAD{1'b0}}};
					load_cfg.ndig   = i2a_pkg::NDIG_BIN;
				end
				default: begin
					load_cfg.digits = {item.value, {PAD{1'b0}}};
					load_cfg.ndig   = i2a_pkg::NDIG_HEX;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (radix_in == i2a_pkg::RADIX_DEC) ? ST_CONV : ST_EMIT;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!dig_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Formatting flags are kept for the decimal path, which loads later.
	always_ff @(posedge clk) begin
		if (accept) begin
			radix_q  <= radix_in;
			prefix_q <= item.with_prefix;
			sign_q   <= sign_in;
		end
	end

	i2a_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && (radix_in == i2a_pkg::RADIX_DEC)),
		.value  (item.value),
		.bcd    (bcd),
		.done   (conv_done)
	);

	i2a_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.cfg       (load_cfg),
		.busy      (dig_busy),
		.chr       (chr),
		.chr_ready (chr_ready)
	);

	i2a_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr       (chr),
		.chr_ready (chr_ready),
		.text      (text)
	);

	// The sequencer must be quiet while a decimal conversion is running.
	`I2A_ASSERT_SAME(a_conv_seq_idle, state_q == ST_CONV, !dig_busy)
	// A converter result only ever arrives while control waits for it.
	`I2A_ASSERT_SAME(a_done_in_conv, conv_done, state_q == ST_CONV)
	// A non-decimal item starts printing straight away.
	`I2A_ASSERT_NEXT(a_direct_load, accept && (radix_in != i2a_pkg::RADIX_DEC),
		(state_q == ST_EMIT) && dig_busy)
	// Every beat carries between one and a full beat of characters.
	`I2A_ASSERT_SAME(a_beat_count, text.valid,
		(text.char_count >= 4'd1) && (text.char_count <= 4'(i2a_pkg::CHARS_PER_BEAT)))

endmodule
